[hdl/detector_hit_time_merge_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hit merge block
// Same-cycle-implication and next-cycle-implication forms.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_HIT_TIME_MERGE_TOP_ASSERT_SVH
`define DETECTOR_HIT_TIME_MERGE_TOP_ASSERT_SVH

// same-cycle implication
`define HMT_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HMT_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/hmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared widths, codes and types for the hit merge block.
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam int HIT_DEPTH_DEF = 32;
  localparam int CHAN_W        = 16;
  localparam int TIME_W        = 32;
  localparam int ENERGY_W      = 40;
  localparam int WORD_W        = 32;
  localparam int TOTAL_W       = 6;
  localparam int STATUS_W      = 3;

  localparam logic [TIME_W-1:0]   TIME_RES_RST = 32'd300;
  localparam logic [WORD_W-1:0]   MUON_CODE    = 32'd13;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX   = {ENERGY_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_MUON    = 3'd0,
    ST_MERGED  = 3'd1,
    ST_NEW     = 3'd2,
    ST_FULL    = 3'd3,
    ST_READOUT = 3'd4
  } status_t;

  // one stored hit
  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [TIME_W-1:0]   hit_time;
    logic [ENERGY_W-1:0] energy;
    logic [WORD_W-1:0]   energy_in;
    logic [WORD_W-1:0]   track;
    logic [WORD_W-1:0]   particle;
  } entry_t;

  // search key presented to every cell
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] hit_time;
  } probe_t;

  // priority chain passed cell to cell
  typedef struct packed {
    logic seen;
    logic merged;
  } scan_t;

  // broadcast controls from the sequencer
  typedef struct packed {
    logic capture;
    logic merge;
    logic append;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hdl/hmt_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmt_in_if
// Deposit / readout request channel, valid-ready.
// ----------------------------------------------------------------------------
interface hmt_in_if;
  import hmt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [WORD_W-1:0] particle_code;
  logic [CHAN_W-1:0]        channel;
  logic [TIME_W-1:0]        hit_time;
  logic [WORD_W-1:0]        energy_deposit;
  logic [WORD_W-1:0]        energy_in;
  logic [WORD_W-1:0]        track_number;

  modport source (
    output valid, func, particle_code, channel, hit_time, energy_deposit,
           energy_in, track_number,
    input  ready
  );

  modport sink (
    input  valid, func, particle_code, channel, hit_time, energy_deposit,
           energy_in, track_number,
    output ready
  );
endinterface
`default_nettype wire

[hdl/hmt_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmt_out_if
// Result channel, valid-ready.
// ----------------------------------------------------------------------------
interface hmt_out_if;
  import hmt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     hit_valid;
  logic                     last;
  logic [CHAN_W-1:0]        out_channel;
  logic [TIME_W-1:0]        out_time;
  logic [ENERGY_W-1:0]      out_energy;
  logic [WORD_W-1:0]        out_energy_in;
  logic [WORD_W-1:0]        out_track;
  logic signed [WORD_W-1:0] out_particle;
  logic [TOTAL_W-1:0]       hit_total;

  modport source (
    output valid, status, hit_valid, last, out_channel, out_time, out_energy,
           out_energy_in, out_track, out_particle, hit_total,
    input  ready
  );

  modport sink (
    input  valid, status, hit_valid, last, out_channel, out_time, out_energy,
           out_energy_in, out_track, out_particle, hit_total,
    output ready
  );
endinterface
`default_nettype wire

[hdl/hmt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmt_cell
// One hit slot: channel/time compare, first-match chain, merge, append, shift.
// ----------------------------------------------------------------------------
module hmt_cell #(
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hmt_pkg::cell_ctrl_t         ctrl,
  input  hmt_pkg::probe_t             probe,
  input  logic [hmt_pkg::TIME_W-1:0]  time_res,
  input  logic [CW-1:0]               count,
  input  hmt_pkg::entry_t             new_entry,
  input  logic [hmt_pkg::WORD_W-1:0]  add_energy,
  input  hmt_pkg::entry_t             next_entry,
  input  hmt_pkg::scan_t              scan_in,
  output hmt_pkg::scan_t              scan_out,
  output hmt_pkg::entry_t             entry
);
  import hmt_pkg::*;

  localparam logic [CW-1:0] IDX_V = CW'(IDX);

  entry_t              entry_r;
  entry_t              entry_nxt;
  logic                match_r;
  logic                win_r;
  logic                occupied;
  logic                is_tail;
  logic [TIME_W-1:0]   diff;
  logic                take;
  logic                do_merge;
  logic [ENERGY_W:0]   sum;
  logic [ENERGY_W-1:0] sat_energy;

  assign occupied = IDX_V < count;
  assign is_tail  = IDX_V == count;

  assign diff = (probe.hit_time >= entry_r.hit_time) ? probe.hit_time - entry_r.hit_time
                                                     : entry_r.hit_time - probe.hit_time;

  // only the first occupied slot with this channel decides
  assign take            = match_r & ~scan_in.seen;
  assign do_merge        = take & win_r;
  assign scan_out.seen   = scan_in.seen | match_r;
  assign scan_out.merged = scan_in.merged | do_merge;

  assign sum        = {1'b0, entry_r.energy} + (ENERGY_W+1)'(add_energy);
  assign sat_energy = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.shift) begin
      entry_nxt = next_entry;
    end else if (ctrl.append && is_tail) begin
      entry_nxt = new_entry;
    end else if (ctrl.merge && do_merge) begin
      entry_nxt.energy = sat_energy;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      win_r   <= 1'b0;
    end else if (ctrl.capture) begin
      match_r <= occupied && (entry_r.channel == probe.channel);
      win_r   <= diff < time_res;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

[hdl/detector_hit_time_merge_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Deposit word: the compare is registered into the cell flags on accept, then the
// first-match chain and update; the next word is taken once the result is registered.
// Readout word: after accept, one hit per cycle out of cell 0 as the chain shifts,
// while the output is not stalled; an empty table gives a single marker word.
// Output stalls hold the sequencer. Synchronous active-low reset empties the table
// and sets the merge window to 300 ns; stored hit contents are not cleared.
// ----------------------------------------------------------------------------
// detector_hit_time_merge_top
// Per-event hit table merging deposits by channel and time window.
// ----------------------------------------------------------------------------
module detector_hit_time_merge_top #(
  parameter int HIT_DEPTH = hmt_pkg::HIT_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hmt_in_if.sink                     in_ch,
  hmt_out_if.source                  out_ch,
  input  logic                       cfg_wr_en,
  input  logic [hmt_pkg::TIME_W-1:0] cfg_wr_data
);
  import hmt_pkg::*;

  localparam int CW = $clog2(HIT_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_V = CW'(HIT_DEPTH);
  localparam logic [CW-1:0] ONE_V   = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_UPD  = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      total_r, total_nxt;
  logic [TIME_W-1:0]  res_r;
  entry_t             item_r;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_hit_valid_r, out_hit_valid_nxt;
  logic               out_last_r, out_last_nxt;
  entry_t             out_entry_r, out_entry_nxt;
  logic [CW-1:0]      out_total_r, out_total_nxt;

  logic               in_acc;
  logic               out_free;
  logic               emit;
  logic               is_muon;
  logic               merged;
  logic               full;
  cell_ctrl_t         ctrl;
  probe_t             probe;
  entry_t             new_entry;

  entry_t             entries [HIT_DEPTH];
  entry_t             next_arr [HIT_DEPTH];
  scan_t              scans [HIT_DEPTH+1];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign out_free    = ~out_valid_r | out_ch.ready;

  assign probe.channel  = in_ch.channel;
  assign probe.hit_time = in_ch.hit_time;

  assign new_entry.channel   = in_ch.channel;
  assign new_entry.hit_time  = in_ch.hit_time;
  assign new_entry.energy    = ENERGY_W'(in_ch.energy_deposit);
  assign new_entry.energy_in = in_ch.energy_in;
  assign new_entry.track     = in_ch.track_number;
  assign new_entry.particle  = in_ch.particle_code;

  assign scans[0] = '0;
  assign is_muon  = (item_r.particle == MUON_CODE);
  assign merged   = scans[HIT_DEPTH].merged;
  assign full     = (count_r == DEPTH_V);

  always_comb begin
    ctrl.capture = in_acc;
    ctrl.merge   = (state_r == S_UPD) && out_free && !is_muon;
    ctrl.append  = ctrl.merge && !merged && !full;
    ctrl.shift   = (state_r == S_READ) && out_free && (count_r != '0);
  end

  genvar gi;
  generate
    for (gi = 0; gi < HIT_DEPTH; gi++) begin : g_cell
      if (gi == HIT_DEPTH - 1) begin : g_tail
        assign next_arr[gi] = entries[gi];
      end else begin : g_mid
        assign next_arr[gi] = entries[gi+1];
      end

      hmt_cell #(
        .CW  (CW),
        .IDX (gi)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .probe      (probe),
        .time_res   (res_r),
        .count      (count_r),
        .new_entry  (item_r),
        .add_energy (item_r.energy[WORD_W-1:0]),
        .next_entry (next_arr[gi]),
        .scan_in    (scans[gi]),
        .scan_out   (scans[gi+1]),
        .entry      (entries[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    total_nxt         = total_r;
    emit              = 1'b0;
    out_status_nxt    = out_status_r;
    out_hit_valid_nxt = out_hit_valid_r;
    out_last_nxt      = out_last_r;
    out_entry_nxt     = out_entry_r;
    out_total_nxt     = out_total_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          total_nxt = count_r;
          state_nxt = in_ch.func ? S_READ : S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          emit              = 1'b1;
          out_hit_valid_nxt = 1'b0;
          out_last_nxt      = 1'b1;
          out_entry_nxt     = '0;
          out_total_nxt     = count_r;
          priority if (is_muon) begin
            out_status_nxt = ST_MUON;
          end else if (merged) begin
            out_status_nxt = ST_MERGED;
          end else if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_NEW;
            count_nxt      = count_r + ONE_V;
            out_total_nxt  = count_r + ONE_V;
          end
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          emit           = 1'b1;
          out_status_nxt = ST_READOUT;
          out_total_nxt  = total_r;
          if (count_r == '0) begin
            // empty table: single marker word
            out_hit_valid_nxt = 1'b0;
            out_last_nxt      = 1'b1;
            out_entry_nxt     = '0;
            state_nxt         = S_IDLE;
          end else begin
            out_hit_valid_nxt = 1'b1;
            out_last_nxt      = (count_r == ONE_V);
            out_entry_nxt     = entries[0];
            count_nxt         = count_r - ONE_V;
            if (count_r == ONE_V) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      res_r       <= TIME_RES_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        res_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= new_entry;
    end
    out_status_r    <= out_status_nxt;
    out_hit_valid_r <= out_hit_valid_nxt;
    out_last_r      <= out_last_nxt;
    out_entry_r     <= out_entry_nxt;
    out_total_r     <= out_total_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.hit_valid     = out_hit_valid_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.out_channel   = out_entry_r.channel;
  assign out_ch.out_time      = out_entry_r.hit_time;
  assign out_ch.out_energy    = out_entry_r.energy;
  assign out_ch.out_energy_in = out_entry_r.energy_in;
  assign out_ch.out_track     = out_entry_r.track;
  assign out_ch.out_particle  = out_entry_r.particle;
  assign out_ch.hit_total     = TOTAL_W'(out_total_r);

endmodule
`default_nettype wire

[hdl/hmt_check.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmt_check
// Port-level checks for the hit merge block, bound to the top level.
// ----------------------------------------------------------------------------
`include "detector_hit_time_merge_top_assert.svh"

module hmt_check (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [hmt_pkg::STATUS_W-1:0]  out_status,
  input wire logic                          out_hit_valid,
  input wire logic                          out_last,
  input wire logic [hmt_pkg::TOTAL_W-1:0]   out_hit_total
);
  import hmt_pkg::*;

  // one word in flight at a time
  `HMT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "word accepted while busy")

  `HMT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_last) && $stable(out_hit_total), "stalled result changed")

  // deposit results are single, empty words
  `HMT_ASSERT_NOW(a_deposit_single, clk, rst_n, out_valid && (out_status != ST_READOUT), out_last && !out_hit_valid, "deposit result not single")

  `HMT_ASSERT_NOW(a_empty_readout, clk, rst_n, out_valid && (out_status == ST_READOUT) && !out_hit_valid, out_last && (out_hit_total == '0), "bad empty readout")

endmodule

bind detector_hit_time_merge_top hmt_check u_hmt_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_hit_valid (out_ch.hit_valid),
  .out_last      (out_ch.last),
  .out_hit_total (out_ch.hit_total)
);
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-event hit merge table. Deposit and readout
// words go in under random valid gaps and result stalls; a built-in table
// model predicts every result word, and each arriving word is compared field
// by field. Covers muon skip, merge windows at 0, 1, 300 and full range,
// first-match search, table overflow, energy saturation and random events.
// ----------------------------------------------------------------------------
module tb;
  import hmt_pkg::*;

  localparam int  TABLE_DEPTH  = HIT_DEPTH_DEF;
  localparam int  RANDOM_WORDS = 16;
  localparam int  IDLE_LIMIT   = 2000;
  localparam int  DRAIN_CYCLES = 40;
  localparam bit  FN_DEPOSIT   = 1'b0;
  localparam bit  FN_READOUT   = 1'b1;

  typedef struct packed {
    logic                     func;
    logic signed [WORD_W-1:0] code;
    logic [CHAN_W-1:0]        chan;
    logic [TIME_W-1:0]        stamp;
    logic [WORD_W-1:0]        edep;
    logic [WORD_W-1:0]        ein;
    logic [WORD_W-1:0]        trk;
  } step_t;

  typedef struct packed {
    status_t                  status;
    logic                     hit_valid;
    logic                     last;
    logic [CHAN_W-1:0]        channel;
    logic [TIME_W-1:0]        stamp;
    logic [ENERGY_W-1:0]      energy;
    logic [WORD_W-1:0]        energy_in;
    logic [WORD_W-1:0]        track;
    logic signed [WORD_W-1:0] particle;
    logic [TOTAL_W-1:0]       total;
  } hit_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [TIME_W-1:0] cfg_wr_data;

  hmt_in_if  in_ch ();
  hmt_out_if out_ch ();

  detector_hit_time_merge_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hit table model
  logic [CHAN_W-1:0]        tbl_chan   [TABLE_DEPTH];
  logic [TIME_W-1:0]        tbl_stamp  [TABLE_DEPTH];
  logic [ENERGY_W-1:0]      tbl_energy [TABLE_DEPTH];
  logic [WORD_W-1:0]        tbl_ein    [TABLE_DEPTH];
  logic [WORD_W-1:0]        tbl_trk    [TABLE_DEPTH];
  logic signed [WORD_W-1:0] tbl_part   [TABLE_DEPTH];
  int                       tbl_count;
  logic [TIME_W-1:0]        merge_window;

  hit_word_t expected_words[$];

  int fail_count = 0;
  int n_deposit, n_readout, n_merged, n_new, n_muon, n_full, n_checked, n_windows;
  int idle_cycles = 0;
  bit quiet;

  function automatic void post_word(status_t st, int idx, bit lst, int total);
    hit_word_t w;
    w = '0;
    w.status = st;
    w.last   = lst;
    w.total  = TOTAL_W'(total);
    if (idx >= 0) begin
      w.hit_valid = 1'b1;
      w.channel   = tbl_chan[idx];
      w.stamp     = tbl_stamp[idx];
      w.energy    = tbl_energy[idx];
      w.energy_in = tbl_ein[idx];
      w.track     = tbl_trk[idx];
      w.particle  = tbl_part[idx];
    end
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void hit_table_update(step_t s);
    int                  found;
    logic [TIME_W-1:0]   diff;
    logic [ENERGY_W:0]   sum;
    found = -1;
    if (s.func == FN_READOUT) begin
      n_readout++;
      if (tbl_count == 0) post_word(ST_READOUT, -1, 1'b1, 0);
      for (int i = 0; i < tbl_count; i++)
        post_word(ST_READOUT, i, i == tbl_count - 1, tbl_count);
      tbl_count = 0;
      return;
    end
    n_deposit++;
    if (s.code == MUON_CODE) begin
      n_muon++;
      post_word(ST_MUON, -1, 1'b1, tbl_count);
      return;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_chan[i] == s.chan) begin
        found = i;
        break;
      end
    end
    if (found >= 0) begin
      diff = (s.stamp >= tbl_stamp[found]) ? s.stamp - tbl_stamp[found]
                                            : tbl_stamp[found] - s.stamp;
      if (diff < merge_window) begin
        sum = {1'b0, tbl_energy[found]} + {{(ENERGY_W-WORD_W+1){1'b0}}, s.edep};
        tbl_energy[found] = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
        n_merged++;
        post_word(ST_MERGED, -1, 1'b1, tbl_count);
        return;
      end
    end
    if (tbl_count >= TABLE_DEPTH) begin
      n_full++;
      post_word(ST_FULL, -1, 1'b1, tbl_count);
      return;
    end
    tbl_chan[tbl_count]   = s.chan;
    tbl_stamp[tbl_count]  = s.stamp;
    tbl_energy[tbl_count] = {{(ENERGY_W-WORD_W){1'b0}}, s.edep};
    tbl_ein[tbl_count]    = s.ein;
    tbl_trk[tbl_count]    = s.trk;
    tbl_part[tbl_count]   = s.code;
    tbl_count++;
    n_new++;
    post_word(ST_NEW, -1, 1'b1, tbl_count);
  endfunction

  // mostly short gaps, a few long ones, none while quiet
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic send_word(input step_t s);
    int gap;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.func           <= s.func;
    in_ch.particle_code  <= s.code;
    in_ch.channel        <= s.chan;
    in_ch.hit_time       <= s.stamp;
    in_ch.energy_deposit <= s.edep;
    in_ch.energy_in      <= s.ein;
    in_ch.track_number   <= s.trk;
    do @(posedge clk); while (!in_ch.ready);
    hit_table_update(s);
  endtask

  task automatic deposit(input logic [WORD_W-1:0] code, input logic [CHAN_W-1:0] chan,
                         input logic [TIME_W-1:0] stamp, input logic [WORD_W-1:0] edep);
    step_t s;
    s.func  = FN_DEPOSIT;
    s.code  = code;
    s.chan  = chan;
    s.stamp = stamp;
    s.edep  = edep;
    s.ein   = $urandom;
    s.trk   = $urandom;
    send_word(s);
  endtask

  task automatic read_out();
    step_t s;
    s = {FN_READOUT, 32'($urandom), 16'($urandom), 32'($urandom), 32'($urandom),
         32'($urandom), 32'($urandom)};
    send_word(s);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_window(input logic [TIME_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    merge_window = value;
    n_windows++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_readout();
    read_out();
  endtask

  // runs at the reset window of 300 ns
  task automatic test_basic_cases();
    step_t s;
    deposit(MUON_CODE, 16'hffff, 32'hffffffff, 32'hffffffff);
    s = {FN_DEPOSIT, 32'sh80000000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0};
    send_word(s);
    s = {FN_DEPOSIT, 32'sh7fffffff, 16'hffff, 32'hffffffff, 32'hffffffff,
         32'hffffffff, 32'hffffffff};
    send_word(s);
    deposit(32'd12, 16'h0000, 32'd299, 32'd5);       // merges, diff just inside
    deposit(32'd14, 16'h0000, 32'd300, 32'd7);       // diff equal to window: new hit
    deposit(-32'sd13, 16'h0000, 32'd301, 32'd9);     // first match only: new hit
    deposit(32'd1, 16'hffff, 32'h0, 32'd11);         // wide diff across zero: new
    deposit(32'd2, 16'hffff, 32'hfffffed5, 32'd3);   // before stored time, inside
    deposit(MUON_CODE, 16'h0000, 32'd0, 32'd1);
    read_out();
    read_out();
  endtask

  task automatic test_window_edges();
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] stamp;
    chan  = 16'($urandom);
    stamp = $urandom;
    write_window('0);
    deposit($urandom, chan, stamp, $urandom);
    deposit($urandom, chan, stamp, $urandom);       // zero window never merges
    read_out();
    write_window(32'd1);
    deposit($urandom, chan, stamp, $urandom);
    deposit($urandom, chan, stamp, $urandom);       // same time merges
    deposit($urandom, chan, stamp + 1, $urandom);   // one ns off: new hit
    read_out();
  endtask

  task automatic test_full_table();
    logic [CHAN_W-1:0] chan0;
    logic [TIME_W-1:0] stamp;
    chan0 = 16'($urandom);
    stamp = $urandom;
    write_window(TIME_RES_RST);
    for (int k = 0; k <= TABLE_DEPTH; k++)
      deposit($urandom, chan0 + CHAN_W'(k), stamp, $urandom);
    deposit($urandom, chan0 + 16'd5, stamp + 32'd10, $urandom);   // merge while full
    deposit($urandom, chan0 + 16'd6, stamp + 32'd5000, $urandom); // dropped
    deposit(MUON_CODE, chan0, stamp, $urandom);
    read_out();
  endtask

  // 257 merges of the largest deposit pass the 40-bit limit
  task automatic test_saturation();
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] stamp;
    chan  = 16'($urandom);
    stamp = $urandom;
    write_window(32'hffffffff);
    for (int k = 0; k < 258; k++)
      deposit($urandom, chan, stamp + $urandom_range(0, 1000), 32'hffffffff);
    deposit(MUON_CODE, chan, stamp, $urandom);
    read_out();
  endtask

  task automatic test_random_events();
    logic [CHAN_W-1:0] pool [8];
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] off;
    step_t             s;
    int                sent;
    int                events;
    int                pool_n;
    int                len;
    int                kind;
    int                r;
    sent   = 0;
    events = 0;
    while (sent < RANDOM_WORDS) begin
      if (events % 3 == 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) write_window('0);
        else if (r == 1) write_window(32'hffffffff);
        else if (r < 5) write_window(TIME_RES_RST);
        else write_window($urandom_range(1, 1000));
      end
      events++;
      quiet  = ($urandom_range(0, 3) == 0);
      pool_n = $urandom_range(1, 6);
      for (int k = 0; k < pool_n; k++) pool[k] = 16'($urandom);
      if ($urandom_range(0, 9) == 0) pool[0] = $urandom_range(0, 1) ? 16'hffff : 16'h0;
      base = $urandom;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 15);
      for (int k = 0; k < len; k++) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          s = {FN_DEPOSIT, 32'($urandom), 16'($urandom), 32'($urandom), 32'($urandom),
               32'($urandom), 32'($urandom)};
          send_word(s);
        end else if (kind == 1) begin
          read_out();
        end else begin
          off     = $urandom_range(0, 700);
          s.func  = FN_DEPOSIT;
          s.code  = (kind < 4) ? MUON_CODE : 32'($urandom);
          s.chan  = pool[$urandom_range(0, pool_n - 1)];
          s.stamp = $urandom_range(0, 1) ? base + off : base - off;
          s.edep  = ($urandom_range(0, 9) == 0) ? 32'hffffffff : 32'($urandom);
          s.ein   = $urandom;
          s.trk   = $urandom;
          send_word(s);
        end
        sent++;
      end
      read_out();
      sent++;
    end
    quiet = 1'b0;
    write_window(TIME_RES_RST);
  endtask

  // ---------------------------------------------------------------- checker

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    hit_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected, status %0d", out_ch.status);
        fail_count++;
      end else begin
        w = expected_words.pop_front();
        n_checked++;
        check_field("status", w.status, out_ch.status);
        check_field("hit_valid", w.hit_valid, out_ch.hit_valid);
        check_field("last", w.last, out_ch.last);
        check_field("out_channel", w.channel, out_ch.out_channel);
        check_field("out_time", w.stamp, out_ch.out_time);
        check_field("out_energy", w.energy, out_ch.out_energy);
        check_field("out_energy_in", w.energy_in, out_ch.out_energy_in);
        check_field("out_track", w.track, out_ch.out_track);
        check_field("out_particle", w.particle, out_ch.out_particle);
        check_field("hit_total", w.total, out_ch.hit_total);
      end
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = idle_gap();
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    in_ch.valid          = 1'b0;
    in_ch.func           = 1'b0;
    in_ch.particle_code  = '0;
    in_ch.channel        = '0;
    in_ch.hit_time       = '0;
    in_ch.energy_deposit = '0;
    in_ch.energy_in      = '0;
    in_ch.track_number   = '0;
    quiet                = 1'b0;
    tbl_count            = 0;
    merge_window         = TIME_RES_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_readout();
    test_basic_cases();
    test_window_edges();
    test_full_table();
    test_saturation();
    test_random_events();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d deposits and %0d readouts; checked %0d result words.",
             n_deposit, n_readout, n_checked);
    $display("Merged %0d, new hits %0d, muons %0d, dropped full %0d, windows set %0d.",
             n_merged, n_new, n_muon, n_full, n_windows);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/hmt_pkg.sv
hdl/hmt_in_if.sv
hdl/hmt_out_if.sv
hdl/hmt_cell.sv
hdl/detector_hit_time_merge_top.sv
hdl/hmt_check.sv
test/tb.sv
